>>> sv/broadcast_pcm_ring_buffer_top_macros.svh
// Assertion macros used by the checker of the broadcast PCM ring buffer.
`ifndef BROADCAST_PCM_RING_BUFFER_TOP_MACROS_SVH
`define BROADCAST_PCM_RING_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define BPCM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpcm same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define BPCM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpcm next-cycle check failed");

`endif

>>> sv/bpcm_pkg.sv
// Shared constants, codes and controller/datapath interface types of the PCM ring buffer.
package bpcm_pkg;

	// Ring geometry (the ring size and the frame size are powers of two).
	localparam int RING_BYTES  = 65536;
	localparam int NUM_READERS = 32;
	localparam int FRAME_BYTES = 4;

	localparam int RING_AW    = $clog2(RING_BYTES);
	localparam int RING_WORDS = RING_BYTES / 2;
	localparam int WORD_AW    = RING_AW - 1;
	localparam int READER_W   = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

	localparam logic [31:0] RING_SPAN    = 32'(RING_BYTES);
	localparam logic [31:0] QUARTER_RING = 32'(RING_BYTES / 4);
	localparam logic [31:0] FRAME_MASK   = ~32'(FRAME_BYTES - 1);

	// Sample conversion constants.
	localparam logic [14:0] PCM_SCALE  = 15'd32767;
	localparam logic [15:0] PCM_MAX    = 16'd32767;
	localparam logic [30:0] FP_INF     = 31'h7F800000;
	localparam logic [30:0] FP_ONE     = 31'h3F800000;
	localparam logic [7:0]  EXP_MIN    = 8'd112;
	localparam logic [7:0]  EXP_SHIFT  = 8'd150;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_ATTACH = 2'd1,
		CMD_DETACH = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_INACTIVE = 2'd2,
		ST_SKIP     = 2'd3
	} status_t;

	// Which response the datapath builds.
	typedef enum logic [1:0] {
		RES_OK       = 2'd0,
		RES_EMPTY    = 2'd1,
		RES_INACTIVE = 2'd2,
		RES_BYTE     = 2'd3
	} res_t;

	// Command bundle from the controller to the datapath.
	typedef struct packed {
		logic cap;
		logic decode;
		logic rnd_load;
		logic wr_en;
		logic attach;
		logic detach;
		logic chk_load;
		logic rd_issue;
		logic res_load;
		res_t res_code;
		logic out_load;
	} bpcm_ctl_t;

	// Status bundle from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic idx_ok;
		logic active;
		logic avail_zero;
	} bpcm_stat_t;

endpackage

>>> sv/bpcm_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module bpcm_ctrl import bpcm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  bpcm_stat_t st,
	output bpcm_ctl_t  ctl
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_DECODE  = 8'b0000_0010,
		S_W_RND   = 8'b0000_0100,
		S_W_STORE = 8'b0000_1000,
		S_R_CHK   = 8'b0001_0000,
		S_R_ADDR  = 8'b0010_0000,
		S_R_DATA  = 8'b0100_0000,
		S_FIN     = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Next state and datapath commands.
	always_comb begin
		ctl          = '0;
		ctl.res_code = RES_OK;
		state_d      = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.cap = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				ctl.decode = 1'b1;
				case (st.cmd)
					CMD_WRITE: begin
						state_d = S_W_RND;
					end
					CMD_ATTACH, CMD_DETACH: begin
						ctl.res_load = 1'b1;
						if (st.idx_ok) begin
							ctl.attach   = (st.cmd == CMD_ATTACH);
							ctl.detach   = (st.cmd == CMD_DETACH);
							ctl.res_code = RES_OK;
						end else begin
							ctl.res_code = RES_INACTIVE;
						end
						state_d = S_FIN;
					end
					CMD_READ: begin
						if (st.idx_ok && st.active) begin
							state_d = S_R_CHK;
						end else begin
							ctl.res_load = 1'b1;
							ctl.res_code = RES_INACTIVE;
							state_d      = S_FIN;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_W_RND: begin
				ctl.rnd_load = 1'b1;
				state_d      = S_W_STORE;
			end
			S_W_STORE: begin
				ctl.wr_en    = 1'b1;
				ctl.res_load = 1'b1;
				ctl.res_code = RES_OK;
				state_d      = S_FIN;
			end
			S_R_CHK: begin
				if (st.avail_zero) begin
					ctl.res_load = 1'b1;
					ctl.res_code = RES_EMPTY;
					state_d      = S_FIN;
				end else begin
					ctl.chk_load = 1'b1;
					state_d      = S_R_ADDR;
				end
			end
			S_R_ADDR: begin
				ctl.rd_issue = 1'b1;
				state_d      = S_R_DATA;
			end
			S_R_DATA: begin
				ctl.res_load = 1'b1;
				ctl.res_code = RES_BYTE;
				state_d      = S_FIN;
			end
			S_FIN: begin
				// Hand the response to the output register once it is free.
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and response-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/bpcm_datapath.sv
// Datapath: sample conversion pipeline, byte ring memory, reader pointers and response registers.
module bpcm_datapath import bpcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bpcm_ctl_t   ctl,
	output bpcm_stat_t  st,
	input  logic [1:0]  cmd,
	input  logic [31:0] sample_bits,
	input  logic [4:0]  reader_index,
	output logic [1:0]  status,
	output logic [7:0]  data_byte,
	output logic [31:0] skipped_bytes
);

	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_FULL = 2'd1,
		CLS_NORM = 2'd2
	} cls_t;

	// Captured request.
	cmd_t        cmd_q;
	logic [31:0] sample_q;
	logic [4:0]  idx_q;

	// Reader state and write pointer.
	logic [31:0]            wp_q;
	logic [31:0]            rp_q [NUM_READERS];
	logic [NUM_READERS-1:0] active_q;

	// Ring memory, one 16-bit sample per word.
	logic [15:0] ring_q [RING_WORDS];
	logic [15:0] rd_word_q;
	logic        byte_hi_q;

	// Conversion pipeline.
	logic [38:0] prod_s1;
	logic [5:0]  shamt_s1;
	cls_t        cls_s1, cls_s2;
	logic        neg_s1, neg_s2;
	logic [24:0] rnd_s2;
	logic [5:0]  rsh_s2;

	// Read path.
	logic [31:0] avail_s1;
	logic [31:0] skip_s2;
	logic        over_s2;

	// Response and output registers.
	status_t     res_status_q, out_status_q;
	logic [7:0]  res_byte_q, out_byte_q;
	logic [31:0] res_skip_q, out_skip_q;

	logic [READER_W-1:0] sel;
	logic [31:0]         rp_sel;
	logic [31:0]         rp_new;
	logic [30:0]         mag_bits;
	logic [7:0]          exp_f;
	logic [23:0]         mant;
	cls_t                cls_d;
	logic [7:0]          shamt_full;
	logic [23:0]         q_trunc;
	logic                round_up;
	logic [5:0]          rsh_d;
	logic [24:0]         shifted;
	logic [15:0]         mag;
	logic [15:0]         pcm;

	assign sel    = idx_q[READER_W-1:0];
	assign rp_sel = rp_q[sel];
	assign rp_new = rp_sel + skip_s2;

	// Status toward the controller.
	assign st.cmd        = cmd_q;
	assign st.idx_ok     = ({1'b0, idx_q} < 6'(NUM_READERS));
	assign st.active     = active_q[sel];
	assign st.avail_zero = (avail_s1 == 32'd0);

	// Request capture.
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q    <= cmd_t'(cmd);
			sample_q <= sample_bits;
			idx_q    <= reader_index;
		end
	end

	// Classify the sample: NaN and magnitudes below 2^-15 give zero, |x| >= 1 clamps.
	assign mag_bits   = sample_q[30:0];
	assign exp_f      = sample_q[30:23];
	assign mant       = {1'b1, sample_q[22:0]};
	assign shamt_full = EXP_SHIFT - exp_f;
	always_comb begin
		if (mag_bits > FP_INF) begin
			cls_d = CLS_ZERO;
		end else if (mag_bits >= FP_ONE) begin
			cls_d = CLS_FULL;
		end else if (exp_f < EXP_MIN) begin
			cls_d = CLS_ZERO;
		end else begin
			cls_d = CLS_NORM;
		end
	end

	// First stage: exact mantissa product and the lag of the addressed reader.
	always_ff @(posedge clk) begin
		if (ctl.decode) begin
			prod_s1  <= 39'(mant) * 39'(PCM_SCALE);
			shamt_s1 <= shamt_full[5:0];
			cls_s1   <= cls_d;
			neg_s1   <= sample_q[31];
			avail_s1 <= wp_q - rp_sel;
		end
	end

	// Round the product to 24 significant bits, nearest even. It has 38 or 39 bits.
	always_comb begin
		if (prod_s1[38]) begin
			q_trunc  = prod_s1[38:15];
			round_up = prod_s1[14] && ((|prod_s1[13:0]) || prod_s1[15]);
			rsh_d    = shamt_s1 - 6'd15;
		end else begin
			q_trunc  = prod_s1[37:14];
			round_up = prod_s1[13] && ((|prod_s1[12:0]) || prod_s1[14]);
			rsh_d    = shamt_s1 - 6'd14;
		end
	end

	// Second stage: rounded significand and the remaining right shift.
	always_ff @(posedge clk) begin
		if (ctl.rnd_load) begin
			rnd_s2 <= {1'b0, q_trunc} + 25'(round_up);
			rsh_s2 <= rsh_d;
			cls_s2 <= cls_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Truncate toward zero, clamp, and apply the sign.
	assign shifted = rnd_s2 >> rsh_s2;
	always_comb begin
		case (cls_s2)
			CLS_FULL: mag = PCM_MAX;
			CLS_NORM: mag = (shifted > 25'(PCM_MAX)) ? PCM_MAX : shifted[15:0];
			default:  mag = 16'd0;
		endcase
		pcm = neg_s2 ? (16'd0 - mag) : mag;
	end

	// Overrun check: skip to a quarter ring behind, in whole frames.
	always_ff @(posedge clk) begin
		if (ctl.chk_load) begin
			over_s2 <= (avail_s1 > RING_SPAN);
			skip_s2 <= (avail_s1 > RING_SPAN) ? ((avail_s1 - QUARTER_RING) & FRAME_MASK)
			                                  : 32'd0;
		end
	end

	// Ring memory: word write for a sample, registered word read for a byte.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			ring_q[wp_q[RING_AW-1:1]] <= pcm;
		end
		if (ctl.rd_issue) begin
			rd_word_q <= ring_q[rp_new[RING_AW-1:1]];
			byte_hi_q <= rp_new[0];
		end
	end

	// Write pointer, reader pointers and active flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= 32'd0;
			active_q <= '0;
			for (int i = 0; i < NUM_READERS; i++) begin
				rp_q[i] <= 32'd0;
			end
		end else begin
			if (ctl.wr_en) begin
				wp_q <= wp_q + 32'd2;
			end
			if (ctl.attach) begin
				rp_q[sel]     <= wp_q;
				active_q[sel] <= 1'b1;
			end
			if (ctl.detach) begin
				active_q[sel] <= 1'b0;
			end
			if (ctl.rd_issue) begin
				rp_q[sel] <= rp_new + 32'd1;
			end
		end
	end

	// Response build.
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			case (ctl.res_code)
				RES_EMPTY: begin
					res_status_q <= ST_EMPTY;
					res_byte_q   <= 8'd0;
					res_skip_q   <= 32'd0;
				end
				RES_INACTIVE: begin
					res_status_q <= ST_INACTIVE;
					res_byte_q   <= 8'd0;
					res_skip_q   <= 32'd0;
				end
				RES_BYTE: begin
					res_status_q <= over_s2 ? ST_SKIP : ST_OK;
					res_byte_q   <= byte_hi_q ? rd_word_q[15:8] : rd_word_q[7:0];
					res_skip_q   <= skip_s2;
				end
				default: begin
					res_status_q <= ST_OK;
					res_byte_q   <= 8'd0;
					res_skip_q   <= 32'd0;
				end
			endcase
		end
	end

	// Output register, held until the response is taken.
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status_q <= res_status_q;
			out_byte_q   <= res_byte_q;
			out_skip_q   <= res_skip_q;
		end
	end

	assign status        = out_status_q;
	assign data_byte     = out_byte_q;
	assign skipped_bytes = out_skip_q;

endmodule

>>> sv/broadcast_pcm_ring_buffer_top.sv
// Top level of the broadcast PCM ring buffer: controller plus datapath.
//
// One writer and up to 32 readers share a 64 KiB byte ring held in an on-chip
// memory of 16-bit words, so a converted sample is stored in a single write.
// Requests are handled one at a time, and each produces exactly one response.
// A write runs the float-to-PCM conversion as a multiply stage and a rounding
// stage, with the shift/clamp done combinationally ahead of the memory write;
// a read goes through lag computation, overrun check, one memory read port
// with a registered output, and byte select. A finished response waits in an
// output register, and the next request is taken and worked on meanwhile. The
// ring needs no clearing after reset: readers only ever see bytes that were
// written.
module broadcast_pcm_ring_buffer_top import bpcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] sample_bits,
	input  logic [4:0]  reader_index,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [7:0]  data_byte,
	output logic [31:0] skipped_bytes
);

	bpcm_ctl_t  ctl;
	bpcm_stat_t st;

	// Sequencer.
	bpcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.st        (st),
		.ctl       (ctl)
	);

	// Storage and arithmetic.
	bpcm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.st            (st),
		.cmd           (cmd),
		.sample_bits   (sample_bits),
		.reader_index  (reader_index),
		.status        (status),
		.data_byte     (data_byte),
		.skipped_bytes (skipped_bytes)
	);

endmodule

>>> sv/bpcm_checker.sv
// Port-level checker for the broadcast PCM ring buffer and its bind to the top level.
`include "broadcast_pcm_ring_buffer_top_macros.svh"

module bpcm_checker import bpcm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [1:0]  cmd,
	input logic [31:0] sample_bits,
	input logic [4:0]  reader_index,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic [7:0]  data_byte,
	input logic [31:0] skipped_bytes
);

	// The block works on one request at a time.
	`BPCM_ASSERT_NXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)

	// A skip count shows up exactly with the overrun status.
	`BPCM_ASSERT_IMP(a_skip_with_overrun, rsp_valid, (status == ST_SKIP) == (skipped_bytes != 32'd0))

	// Empty and inactive responses carry no byte and no skip.
	`BPCM_ASSERT_IMP(a_no_data_on_miss, rsp_valid && (status == ST_EMPTY || status == ST_INACTIVE), data_byte == 8'd0 && skipped_bytes == 32'd0)

	// A stalled response holds.
	`BPCM_ASSERT_NXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(data_byte) && $stable(skipped_bytes))

endmodule

bind broadcast_pcm_ring_buffer_top bpcm_checker u_bpcm_checker (.*);
